// ----- hw/rtl/ksc_pkg.sv -----
// shared types, constants and the control program of the keyword substitution cipher
package ksc_pkg;

  // alphabet and ascii constants
  localparam int ALPHA       = 26;
  localparam int KEYWORD_MAX = 25;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_A     = 8'd65;
  localparam byte_t CH_Z     = 8'd90;
  localparam byte_t CASE_GAP = 8'd32;
  localparam byte_t CH_LA    = CH_A + CASE_GAP;
  localparam byte_t CH_LZ    = CH_Z + CASE_GAP;
  localparam byte_t ALPHA_B  = byte_t'(ALPHA);

  // widths that follow from the store depths
  localparam int KW_AW  = (KEYWORD_MAX > 1) ? $clog2(KEYWORD_MAX) : 1;
  localparam int KW_LW  = $clog2(KEYWORD_MAX + 1);
  localparam int ST_AW  = $clog2(ALPHA);
  localparam int CNT_W  = $clog2(ALPHA + 1);
  localparam int PC_W   = 5;

  typedef logic [KW_AW-1:0] kw_addr_t;
  typedef logic [KW_LW-1:0] kw_len_t;
  typedef logic [ST_AW-1:0] st_addr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PC_W-1:0]  pc_t;
  typedef logic [4:0]       shift_t;
  typedef logic [4:0]       cfg_data_t;
  typedef logic [1:0]       cfg_index_t;

  localparam cnt_t LAST_IDX = cnt_t'(ALPHA - 1);

  // item codes
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_BUILD  = 2'd2,
    ACT_CHAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_SHIFT_ENC = 2'd0,
    MODE_SHIFT_DEC = 2'd1,
    MODE_SUB_ENC   = 2'd2,
    MODE_SUB_DEC   = 2'd3
  } mode_t;

  // configuration register indexes
  localparam cfg_index_t CFG_CIPHER_MODE  = 2'd0;
  localparam cfg_index_t CFG_SHIFT_AMOUNT = 2'd1;

  // payload structs
  typedef struct packed {
    action_t action;
    byte_t   in_char;
  } in_item_t;

  typedef struct packed {
    byte_t out_char;
    logic  is_status;
    logic  key_error;
  } out_item_t;

  // datapath operations of one control word
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_CLR_KW,
    OP_APPEND,
    OP_SHIFT_ENC,
    OP_SHIFT_DEC,
    OP_SUB_ADDR,
    OP_EMIT_ST,
    OP_EMIT_CH,
    OP_EMIT_P,
    OP_CLR_P,
    OP_INC_P,
    OP_RD_ST_P,
    OP_BUILD_INIT,
    OP_RD_KS_I,
    OP_LATCH_E,
    OP_RD_KS_P,
    OP_KS_CMP,
    OP_WR_E,
    OP_NEXT_UP,
    OP_WR_UP,
    OP_BUILD_OK,
    OP_BUILD_FAIL
  } dp_op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_DISPATCH,
    C_SUB_MISS,
    C_DEC_MISS,
    C_ST_EQ_CH,
    C_P_NOT_LAST,
    C_KW_BAD,
    C_I_GE_LEN,
    C_P_GE_I,
    C_I_LAST,
    C_P_GE_LEN,
    C_ST_NE_UP,
    C_I_NOT_LAST
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    pc_t    target;
  } ctrl_word_t;

  // program step addresses
  localparam pc_t S_IDLE    = 5'd0;
  localparam pc_t S_DISP    = 5'd1;
  localparam pc_t S_CLR     = 5'd2;
  localparam pc_t S_APPEND  = 5'd3;
  localparam pc_t S_SHE     = 5'd4;
  localparam pc_t S_SHD     = 5'd5;
  localparam pc_t S_SBE0    = 5'd6;
  localparam pc_t S_SBE1    = 5'd7;
  localparam pc_t S_SBD0    = 5'd8;
  localparam pc_t S_SBD1    = 5'd9;
  localparam pc_t S_SBD2    = 5'd10;
  localparam pc_t S_SBD3    = 5'd11;
  localparam pc_t S_EMIT_CH = 5'd12;
  localparam pc_t S_SBD_HIT = 5'd13;
  localparam pc_t S_B_INIT  = 5'd14;
  localparam pc_t S_B_KI    = 5'd15;
  localparam pc_t S_B_LATCH = 5'd16;
  localparam pc_t S_B_KP    = 5'd17;
  localparam pc_t S_B_KCMP  = 5'd18;
  localparam pc_t S_B_KWR   = 5'd19;
  localparam pc_t S_B_KJMP  = 5'd20;
  localparam pc_t S_B_F0    = 5'd21;
  localparam pc_t S_B_F1    = 5'd22;
  localparam pc_t S_B_F2    = 5'd23;
  localparam pc_t S_B_F3    = 5'd24;
  localparam pc_t S_B_FW    = 5'd25;
  localparam pc_t S_B_DONE  = 5'd26;
  localparam pc_t S_B_FAIL  = 5'd27;

  // character classes
  function automatic logic is_upper(byte_t c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic is_lower(byte_t c);
    return (c >= CH_LA) && (c <= CH_LZ);
  endfunction

  function automatic byte_t fold_case(byte_t c);
    return is_lower(c) ? c - CASE_GAP : c;
  endfunction

  function automatic ctrl_word_t mk_word(dp_op_t op, cond_t cond, pc_t target);
    ctrl_word_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // entry step of each item kind
  function automatic pc_t dispatch_step(action_t a, mode_t m);
    pc_t s;
    s = S_IDLE;
    case (a)
      ACT_CLEAR:  s = S_CLR;
      ACT_APPEND: s = S_APPEND;
      ACT_BUILD:  s = S_B_INIT;
      ACT_CHAR: begin
        case (m)
          MODE_SHIFT_ENC: s = S_SHE;
          MODE_SHIFT_DEC: s = S_SHD;
          MODE_SUB_ENC:   s = S_SBE0;
          MODE_SUB_DEC:   s = S_SBD0;
          default:        s = S_IDLE;
        endcase
      end
      default: s = S_IDLE;
    endcase
    return s;
  endfunction

  // control program rom
  function automatic ctrl_word_t ucode(pc_t pc);
    ctrl_word_t w;
    case (pc)
      S_IDLE:    w = mk_word(OP_LATCH,      C_NO_START,   S_IDLE);
      S_DISP:    w = mk_word(OP_NOP,        C_DISPATCH,   S_IDLE);
      S_CLR:     w = mk_word(OP_CLR_KW,     C_ALWAYS,     S_IDLE);
      S_APPEND:  w = mk_word(OP_APPEND,     C_ALWAYS,     S_IDLE);
      S_SHE:     w = mk_word(OP_SHIFT_ENC,  C_ALWAYS,     S_IDLE);
      S_SHD:     w = mk_word(OP_SHIFT_DEC,  C_ALWAYS,     S_IDLE);
      S_SBE0:    w = mk_word(OP_SUB_ADDR,   C_SUB_MISS,   S_EMIT_CH);
      S_SBE1:    w = mk_word(OP_EMIT_ST,    C_ALWAYS,     S_IDLE);
      S_SBD0:    w = mk_word(OP_CLR_P,      C_DEC_MISS,   S_EMIT_CH);
      S_SBD1:    w = mk_word(OP_RD_ST_P,    C_NEVER,      S_IDLE);
      S_SBD2:    w = mk_word(OP_NOP,        C_ST_EQ_CH,   S_SBD_HIT);
      S_SBD3:    w = mk_word(OP_INC_P,      C_P_NOT_LAST, S_SBD1);
      S_EMIT_CH: w = mk_word(OP_EMIT_CH,    C_ALWAYS,     S_IDLE);
      S_SBD_HIT: w = mk_word(OP_EMIT_P,     C_ALWAYS,     S_IDLE);
      S_B_INIT:  w = mk_word(OP_BUILD_INIT, C_KW_BAD,     S_B_FAIL);
      S_B_KI:    w = mk_word(OP_RD_KS_I,    C_I_GE_LEN,   S_B_F0);
      S_B_LATCH: w = mk_word(OP_LATCH_E,    C_NEVER,      S_IDLE);
      S_B_KP:    w = mk_word(OP_RD_KS_P,    C_P_GE_I,     S_B_KWR);
      S_B_KCMP:  w = mk_word(OP_KS_CMP,     C_ALWAYS,     S_B_KP);
      S_B_KWR:   w = mk_word(OP_WR_E,       C_I_LAST,     S_B_DONE);
      S_B_KJMP:  w = mk_word(OP_NOP,        C_ALWAYS,     S_B_KI);
      S_B_F0:    w = mk_word(OP_CLR_P,      C_NEVER,      S_IDLE);
      S_B_F1:    w = mk_word(OP_RD_ST_P,    C_P_GE_LEN,   S_B_FW);
      S_B_F2:    w = mk_word(OP_INC_P,      C_ST_NE_UP,   S_B_F1);
      S_B_F3:    w = mk_word(OP_NEXT_UP,    C_ALWAYS,     S_B_F1);
      S_B_FW:    w = mk_word(OP_WR_UP,      C_I_NOT_LAST, S_B_F1);
      S_B_DONE:  w = mk_word(OP_BUILD_OK,   C_ALWAYS,     S_IDLE);
      S_B_FAIL:  w = mk_word(OP_BUILD_FAIL, C_ALWAYS,     S_IDLE);
      default:   w = mk_word(OP_NOP,        C_ALWAYS,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/ksc_ram.sv -----
// generic single-port-write ram with a registered read port
module ksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/keyword_substitution_cipher.sv -----
// top level of the keyword substitution cipher with a shift mode
//
// An item is taken at a rising edge with start high and busy low; item.action
// selects clear keyword, append keyword letter, build table or message char.
// Clear and append give no result; build gives one status result, a message
// char gives one enciphered or deciphered byte. A result sits on the result port for one
// cycle with done high and cannot be held off by the receiver.
// Config (cipher_mode, shift_amount) is written over cfg_valid/cfg_ready,
// always ready; write it only while the block is idle, the block does not enforce it.
// Control is a microprogram: one control word per step, a step counter and
// conditional jumps. Each table or keyword entry costs one ram read step.
// Substitution decrypt reads table entries in order up to a match; a good
// build writes the keyword entries, then fills the remaining entries with
// ascending letters not already used by the keyword part.
// The result strobe is registered, in the cycle after the last step of an item.
// Reset clears the keyword length, error flag, table valid flag and config;
// the keyword and table rams are not cleared and need no sweep.
module keyword_substitution_cipher (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ksc_pkg::in_item_t   item,
  output logic                done,
  output ksc_pkg::out_item_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ksc_pkg::cfg_index_t cfg_index,
  input  ksc_pkg::cfg_data_t  cfg_data
);

  ksc_pkg::pc_t        pc;
  ksc_pkg::pc_t        pc_next;
  ksc_pkg::ctrl_word_t cw;
  logic                take;
  logic                accept;
  logic                emit;

  ksc_pkg::action_t    act;
  ksc_pkg::byte_t      ch;
  ksc_pkg::byte_t      fch;
  ksc_pkg::byte_t      e;
  ksc_pkg::byte_t      up;
  ksc_pkg::byte_t      down;
  ksc_pkg::cnt_t       i;
  ksc_pkg::cnt_t       p;
  ksc_pkg::cnt_t       len_c;
  ksc_pkg::kw_len_t    kw_len;
  logic                kw_bad;
  logic                tbl_valid;
  ksc_pkg::mode_t      mode;
  ksc_pkg::shift_t     shift;
  ksc_pkg::shift_t     shift_k;
  ksc_pkg::byte_t      enc_sum;
  ksc_pkg::byte_t      dec_diff;
  ksc_pkg::byte_t      enc_char;
  ksc_pkg::byte_t      dec_char;
  ksc_pkg::byte_t      sub_idx;
  logic                append_ok;
  logic                sub_ok;
  logic                dec_ok;

  logic                ks_we;
  ksc_pkg::kw_addr_t   ks_waddr;
  ksc_pkg::byte_t      ks_wdata;
  logic                ks_re;
  ksc_pkg::kw_addr_t   ks_raddr;
  ksc_pkg::byte_t      ks_rdata;
  logic                st_we;
  ksc_pkg::st_addr_t   st_waddr;
  ksc_pkg::byte_t      st_wdata;
  logic                st_re;
  ksc_pkg::st_addr_t   st_raddr;
  ksc_pkg::byte_t      st_rdata;

  // handshake
  assign busy      = (pc != ksc_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // control word of the current step
  assign cw = ksc_pkg::ucode(pc);

  // character arithmetic
  assign fch      = ksc_pkg::fold_case(ch);
  assign len_c    = ksc_pkg::cnt_t'(kw_len);
  assign shift_k  = (shift >= ksc_pkg::shift_t'(ksc_pkg::ALPHA)) ?
                    shift - ksc_pkg::shift_t'(ksc_pkg::ALPHA) : shift;
  assign enc_sum  = fch + ksc_pkg::byte_t'(shift_k);
  assign dec_diff = ch - ksc_pkg::byte_t'(shift_k);
  assign enc_char = !ksc_pkg::is_upper(fch) ? fch :
                    (enc_sum > ksc_pkg::CH_Z) ? enc_sum - ksc_pkg::ALPHA_B : enc_sum;
  assign dec_char = !ksc_pkg::is_upper(ch) ? ch :
                    (dec_diff < ksc_pkg::CH_A) ? dec_diff + ksc_pkg::ALPHA_B : dec_diff;
  assign sub_idx  = fch - ksc_pkg::CH_A;

  assign append_ok = ksc_pkg::is_upper(fch) &&
                     (kw_len < ksc_pkg::kw_len_t'(ksc_pkg::KEYWORD_MAX));
  assign sub_ok    = ksc_pkg::is_upper(fch) && tbl_valid;
  assign dec_ok    = ksc_pkg::is_upper(ch) && tbl_valid;

  // jump condition
  always_comb begin
    case (cw.cond)
      ksc_pkg::C_NEVER:      take = 1'b0;
      ksc_pkg::C_ALWAYS:     take = 1'b1;
      ksc_pkg::C_NO_START:   take = !start;
      ksc_pkg::C_DISPATCH:   take = 1'b1;
      ksc_pkg::C_SUB_MISS:   take = !sub_ok;
      ksc_pkg::C_DEC_MISS:   take = !dec_ok;
      ksc_pkg::C_ST_EQ_CH:   take = (st_rdata == ch);
      ksc_pkg::C_P_NOT_LAST: take = (p != ksc_pkg::LAST_IDX);
      ksc_pkg::C_KW_BAD:     take = kw_bad;
      ksc_pkg::C_I_GE_LEN:   take = (i >= len_c);
      ksc_pkg::C_P_GE_I:     take = (p >= i);
      ksc_pkg::C_I_LAST:     take = (i == ksc_pkg::LAST_IDX);
      ksc_pkg::C_P_GE_LEN:   take = (p >= len_c);
      ksc_pkg::C_ST_NE_UP:   take = (st_rdata != up);
      ksc_pkg::C_I_NOT_LAST: take = (i != ksc_pkg::LAST_IDX);
      default:               take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (cw.cond == ksc_pkg::C_DISPATCH) begin
      pc_next = ksc_pkg::dispatch_step(act, mode);
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + ksc_pkg::pc_t'(1);
    end
  end

  assign emit = cw.op inside {ksc_pkg::OP_SHIFT_ENC, ksc_pkg::OP_SHIFT_DEC,
                              ksc_pkg::OP_EMIT_ST, ksc_pkg::OP_EMIT_CH,
                              ksc_pkg::OP_EMIT_P, ksc_pkg::OP_BUILD_OK,
                              ksc_pkg::OP_BUILD_FAIL};

  // keyword ram ports
  assign ks_we    = (cw.op == ksc_pkg::OP_APPEND) && append_ok;
  assign ks_waddr = kw_len[ksc_pkg::KW_AW-1:0];
  assign ks_wdata = fch;
  assign ks_re    = ((cw.op == ksc_pkg::OP_RD_KS_I) && (i < len_c)) ||
                    (cw.op == ksc_pkg::OP_RD_KS_P);
  assign ks_raddr = (cw.op == ksc_pkg::OP_RD_KS_I) ? i[ksc_pkg::KW_AW-1:0] :
                    p[ksc_pkg::KW_AW-1:0];

  // table ram ports
  assign st_we    = cw.op inside {ksc_pkg::OP_WR_E, ksc_pkg::OP_WR_UP};
  assign st_waddr = i[ksc_pkg::ST_AW-1:0];
  assign st_wdata = (cw.op == ksc_pkg::OP_WR_E) ? e : up;
  assign st_re    = ((cw.op == ksc_pkg::OP_SUB_ADDR) && sub_ok) ||
                    (cw.op == ksc_pkg::OP_RD_ST_P);
  assign st_raddr = (cw.op == ksc_pkg::OP_SUB_ADDR) ? sub_idx[ksc_pkg::ST_AW-1:0] :
                    p[ksc_pkg::ST_AW-1:0];

  ksc_ram #(
    .WIDTH (8),
    .DEPTH (ksc_pkg::KEYWORD_MAX)
  ) u_keyword_ram (
    .clk   (clk),
    .we    (ks_we),
    .waddr (ks_waddr),
    .wdata (ks_wdata),
    .re    (ks_re),
    .raddr (ks_raddr),
    .rdata (ks_rdata)
  );

  ksc_ram #(
    .WIDTH (8),
    .DEPTH (ksc_pkg::ALPHA)
  ) u_table_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // control state and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= ksc_pkg::S_IDLE;
      done      <= 1'b0;
      kw_len    <= '0;
      kw_bad    <= 1'b0;
      tbl_valid <= 1'b0;
      mode      <= ksc_pkg::MODE_SHIFT_ENC;
      shift     <= '0;
    end else begin
      pc   <= pc_next;
      done <= emit;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ksc_pkg::CFG_CIPHER_MODE) begin
          mode <= ksc_pkg::mode_t'(cfg_data[1:0]);
        end else if (cfg_index == ksc_pkg::CFG_SHIFT_AMOUNT) begin
          shift <= cfg_data;
        end
      end
      case (cw.op)
        ksc_pkg::OP_CLR_KW: begin
          kw_len <= '0;
          kw_bad <= 1'b0;
        end
        ksc_pkg::OP_APPEND: begin
          if (append_ok) begin
            kw_len <= kw_len + ksc_pkg::kw_len_t'(1);
          end else begin
            kw_bad <= 1'b1;
          end
        end
        ksc_pkg::OP_BUILD_OK:   tbl_valid <= 1'b1;
        ksc_pkg::OP_BUILD_FAIL: tbl_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= item.action;
      ch  <= item.in_char;
    end
    case (cw.op)
      ksc_pkg::OP_SUB_ADDR: ch <= fch;
      ksc_pkg::OP_CLR_P:    p  <= '0;
      ksc_pkg::OP_INC_P:    p  <= p + ksc_pkg::cnt_t'(1);
      ksc_pkg::OP_BUILD_INIT: begin
        i    <= '0;
        down <= ksc_pkg::CH_Z;
        up   <= ksc_pkg::CH_A;
      end
      ksc_pkg::OP_LATCH_E: begin
        e <= ks_rdata;
        p <= '0;
      end
      // repeat of an earlier keyword letter takes the descending counter
      ksc_pkg::OP_KS_CMP: begin
        if (ks_rdata == e) begin
          e    <= down;
          down <= down - ksc_pkg::byte_t'(1);
        end
        p <= p + ksc_pkg::cnt_t'(1);
      end
      ksc_pkg::OP_WR_E: i <= i + ksc_pkg::cnt_t'(1);
      ksc_pkg::OP_NEXT_UP: begin
        up <= up + ksc_pkg::byte_t'(1);
        p  <= '0;
      end
      ksc_pkg::OP_WR_UP: begin
        up <= up + ksc_pkg::byte_t'(1);
        i  <= i + ksc_pkg::cnt_t'(1);
        p  <= '0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    case (cw.op)
      ksc_pkg::OP_SHIFT_ENC: result <= '{out_char: enc_char, is_status: 1'b0, key_error: 1'b0};
      ksc_pkg::OP_SHIFT_DEC: result <= '{out_char: dec_char, is_status: 1'b0, key_error: 1'b0};
      ksc_pkg::OP_EMIT_ST:   result <= '{out_char: st_rdata, is_status: 1'b0, key_error: 1'b0};
      ksc_pkg::OP_EMIT_CH:   result <= '{out_char: ch, is_status: 1'b0, key_error: 1'b0};
      ksc_pkg::OP_EMIT_P: begin
        result <= '{out_char: ksc_pkg::CH_A + ksc_pkg::byte_t'(p),
                    is_status: 1'b0, key_error: 1'b0};
      end
      ksc_pkg::OP_BUILD_OK:   result <= '{out_char: 8'd0, is_status: 1'b1, key_error: 1'b0};
      ksc_pkg::OP_BUILD_FAIL: result <= '{out_char: 8'd0, is_status: 1'b1, key_error: 1'b1};
      default: ;
    endcase
  end

  // an accepted item keeps the sequencer busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not start the sequencer");

  // every result comes out of a running program
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running item");

  // a status result belongs to a build item and carries no character
  a_status_build: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_status) |-> ((act == ksc_pkg::ACT_BUILD) && (result.out_char == 8'd0)))
    else $error("status result not tied to a build item");

  // the table becomes valid only with a clean build status
  a_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(tbl_valid) |-> (done && result.is_status && !result.key_error))
    else $error("table valid rose without a clean build");

endmodule

// ----- tb/keyword_substitution_cipher_tb.sv -----
// self-checking testbench for the keyword substitution cipher engine
module keyword_substitution_cipher_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1950;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 8;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  ksc_pkg::in_item_t   item;
  logic                done;
  ksc_pkg::out_item_t  result;
  logic                cfg_valid;
  logic                cfg_ready;
  ksc_pkg::cfg_index_t cfg_index;
  ksc_pkg::cfg_data_t  cfg_data;

  keyword_substitution_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // stimulus table row: either a register setting or an item
  typedef struct {
    bit                 is_cfg;
    bit                 typed;
    ksc_pkg::in_item_t  it;
    ksc_pkg::out_item_t want;
    ksc_pkg::mode_t     m;
    ksc_pkg::shift_t    s;
  } row_t;

  // predictor state
  ksc_pkg::byte_t     kw_letters [ksc_pkg::KEYWORD_MAX];
  int                 kw_count;
  bit                 kw_bad;
  ksc_pkg::byte_t     sub_tbl [ksc_pkg::ALPHA];
  bit                 tbl_ok;
  ksc_pkg::mode_t     cur_mode;
  ksc_pkg::shift_t    cur_shift;

  ksc_pkg::out_item_t cipher_out_q[$];
  row_t               rows[$];
  int                 mismatches;
  int                 n_items;
  int                 gap_pct;
  int                 stall_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_up(ksc_pkg::byte_t c);
    return c >= ksc_pkg::CH_A && c <= ksc_pkg::CH_Z;
  endfunction

  function automatic bit is_low(ksc_pkg::byte_t c);
    return c >= ksc_pkg::CH_A + ksc_pkg::CASE_GAP && c <= ksc_pkg::CH_Z + ksc_pkg::CASE_GAP;
  endfunction

  function automatic ksc_pkg::in_item_t mk(ksc_pkg::action_t a, ksc_pkg::byte_t c);
    ksc_pkg::in_item_t it;
    it.action  = a;
    it.in_char = c;
    return it;
  endfunction

  // expand the keyword into the substitution table
  task automatic expand_keyword();
    int             down;
    int             up;
    bit             hit;
    ksc_pkg::byte_t e;
    down = ksc_pkg::CH_Z;
    up   = ksc_pkg::CH_A;
    for (int i = 0; i < ksc_pkg::ALPHA; i++) begin
      if (i < kw_count) begin
        e = kw_letters[i];
        // repeats of earlier keyword letters draw from the descending counter
        for (int p = 0; p < i; p++) begin
          if (kw_letters[p] == e) begin
            e = ksc_pkg::byte_t'(down);
            down = (down - 1) & 8'hFF;
          end
        end
        sub_tbl[i] = e;
      end else begin
        // next ascending value not among the keyword part
        hit = 1'b1;
        while (hit && up < 512) begin
          hit = 1'b0;
          for (int p = 0; p < kw_count; p++) begin
            if (sub_tbl[p] == ksc_pkg::byte_t'(up)) hit = 1'b1;
          end
          if (hit) up++;
        end
        sub_tbl[i] = ksc_pkg::byte_t'(up);
        up++;
      end
    end
    tbl_ok = 1'b1;
  endtask

  // enciphered or deciphered byte for the current settings
  function automatic ksc_pkg::byte_t encode_byte(ksc_pkg::byte_t c);
    int  v;
    int  k;
    bit  found;
    v = c;
    k = cur_shift % ksc_pkg::ALPHA;
    found = 1'b0;
    case (cur_mode)
      ksc_pkg::MODE_SHIFT_ENC: begin
        if (is_low(c)) v = v - ksc_pkg::CASE_GAP;
        if (v >= ksc_pkg::CH_A && v <= ksc_pkg::CH_Z) begin
          v = v + k;
          if (v > ksc_pkg::CH_Z) v = v - ksc_pkg::ALPHA;
        end
      end
      ksc_pkg::MODE_SHIFT_DEC: begin
        if (is_up(c)) begin
          v = v - k;
          if (v < ksc_pkg::CH_A) v = v + ksc_pkg::ALPHA;
        end
      end
      ksc_pkg::MODE_SUB_ENC: begin
        if (is_low(c)) v = v - ksc_pkg::CASE_GAP;
        if (v >= ksc_pkg::CH_A && v <= ksc_pkg::CH_Z && tbl_ok) v = sub_tbl[v - ksc_pkg::CH_A];
      end
      default: begin
        if (is_up(c) && tbl_ok) begin
          for (int p = 0; p < ksc_pkg::ALPHA; p++) begin
            if (!found && sub_tbl[p] == c) begin
              v = ksc_pkg::CH_A + p;
              found = 1'b1;
            end
          end
        end
      end
    endcase
    return ksc_pkg::byte_t'(v);
  endfunction

  // advance the predicted state by one accepted item
  task automatic step_cipher(ksc_pkg::in_item_t it);
    ksc_pkg::out_item_t r;
    ksc_pkg::byte_t     c;
    c = it.in_char;
    case (it.action)
      ksc_pkg::ACT_CLEAR: begin
        kw_count = 0;
        kw_bad   = 1'b0;
      end
      ksc_pkg::ACT_APPEND: begin
        if (is_low(c)) c = c - ksc_pkg::CASE_GAP;
        if (!is_up(c) || kw_count >= ksc_pkg::KEYWORD_MAX) begin
          kw_bad = 1'b1;
        end else begin
          kw_letters[kw_count] = c;
          kw_count++;
        end
      end
      ksc_pkg::ACT_BUILD: begin
        if (kw_bad) tbl_ok = 1'b0;
        else expand_keyword();
        r.out_char  = 8'd0;
        r.is_status = 1'b1;
        r.key_error = kw_bad;
        cipher_out_q.push_back(r);
      end
      default: begin
        r.out_char  = encode_byte(c);
        r.is_status = 1'b0;
        r.key_error = 1'b0;
        cipher_out_q.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // offer one item, idling at random first; start stays high after acceptance
  task automatic send_item(ksc_pkg::in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    step_cipher(it);
    n_items++;
  endtask

  // hold off until every pending result is in and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (cipher_out_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write both registers back to back; only called once drained
  task automatic set_cipher(ksc_pkg::mode_t m, ksc_pkg::shift_t s);
    cfg_valid <= 1'b1;
    cfg_index <= ksc_pkg::CFG_CIPHER_MODE;
    cfg_data  <= ksc_pkg::cfg_data_t'(m);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_mode  = m;
    cfg_index <= ksc_pkg::CFG_SHIFT_AMOUNT;
    cfg_data  <= ksc_pkg::cfg_data_t'(s);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_shift = s;
    cfg_valid <= 1'b0;
  endtask

  function automatic row_t blank_row();
    row_t r;
    r.is_cfg = 1'b0;
    r.typed  = 1'b0;
    r.it     = '0;
    r.want   = '0;
    r.m      = ksc_pkg::MODE_SHIFT_ENC;
    r.s      = '0;
    return r;
  endfunction

  task automatic add_row(ksc_pkg::action_t a, ksc_pkg::byte_t c);
    row_t r;
    r = blank_row();
    r.it = mk(a, c);
    rows.push_back(r);
  endtask

  task automatic add_chk(ksc_pkg::action_t a, ksc_pkg::byte_t c, ksc_pkg::byte_t oc,
                         logic st, logic er);
    row_t r;
    r = blank_row();
    r.it = mk(a, c);
    r.typed = 1'b1;
    r.want.out_char  = oc;
    r.want.is_status = st;
    r.want.key_error = er;
    rows.push_back(r);
  endtask

  task automatic add_cfg(ksc_pkg::mode_t m, ksc_pkg::shift_t s);
    row_t r;
    r = blank_row();
    r.is_cfg = 1'b1;
    r.m = m;
    r.s = s;
    rows.push_back(r);
  endtask

  function automatic ksc_pkg::byte_t rand_letter(int pool);
    ksc_pkg::byte_t c;
    c = ksc_pkg::CH_A + ksc_pkg::byte_t'($urandom_range(pool - 1));
    if ($urandom_range(1)) c = c + ksc_pkg::CASE_GAP;
    return c;
  endfunction

  function automatic ksc_pkg::byte_t rand_non_letter();
    ksc_pkg::byte_t c;
    do c = ksc_pkg::byte_t'($urandom); while (is_up(c) || is_low(c));
    return c;
  endfunction

  // one keyword sequence with message traffic, or a burst of noise
  task automatic play_sequence();
    int             kind;
    int             len;
    int             pool;
    int             bad_at;
    int             r;
    ksc_pkg::byte_t c;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 8))
        send_item(mk(ksc_pkg::action_t'($urandom_range(3)), ksc_pkg::byte_t'($urandom)));
    end else begin
      send_item(mk(ksc_pkg::ACT_CLEAR, ksc_pkg::byte_t'($urandom)));
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(8);
      else if (r < 90) len = $urandom_range(9, 24);
      else len = $urandom_range(25, 27);
      // small pools give repeated letters and push the counter down
      pool = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : ksc_pkg::ALPHA;
      bad_at = (kind < 24) ? $urandom_range(len) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == bad_at) send_item(mk(ksc_pkg::ACT_APPEND, rand_non_letter()));
        send_item(mk(ksc_pkg::ACT_APPEND, rand_letter(pool)));
      end
      if (bad_at == len) send_item(mk(ksc_pkg::ACT_APPEND, rand_non_letter()));
      send_item(mk(ksc_pkg::ACT_BUILD, ksc_pkg::byte_t'($urandom)));
      repeat ($urandom_range(12)) begin
        c = ($urandom_range(99) < 65) ? rand_letter(ksc_pkg::ALPHA) :
            ksc_pkg::byte_t'($urandom);
        send_item(mk(ksc_pkg::ACT_CHAR, c));
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    ksc_pkg::out_item_t want;
    if (!rst && done) begin
      if (cipher_out_q.size() == 0) begin
        report_mismatch("result with none pending", result, 0);
      end else begin
        want = cipher_out_q.pop_front();
        if (result.out_char != want.out_char)
          report_mismatch("out_char", result.out_char, want.out_char);
        if (result.is_status != want.is_status)
          report_mismatch("is_status", result.is_status, want.is_status);
        if (result.key_error != want.key_error)
          report_mismatch("key_error", result.key_error, want.key_error);
      end
    end
  end

  // watchdog on cycles with no item, result or register write taken
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("** keyword_substitution_cipher: FAILED **");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    ksc_pkg::mode_t  m;
    ksc_pkg::shift_t s;
    row_t            r;
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= ksc_pkg::CFG_CIPHER_MODE;
    cfg_data  <= '0;
    stall_cnt  = 0;
    mismatches = 0;
    n_items    = 0;
    kw_count   = 0;
    kw_bad     = 1'b0;
    tbl_ok     = 1'b0;
    cur_mode   = ksc_pkg::MODE_SHIFT_ENC;
    cur_shift  = '0;
    gap_pct    = 25;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, then each mode at the shift extremes
    add_chk(ksc_pkg::ACT_CHAR, "a", "A", 1'b0, 1'b0);
    add_chk(ksc_pkg::ACT_CHAR, 8'hFF, 8'hFF, 1'b0, 1'b0);
    add_chk(ksc_pkg::ACT_CHAR, 8'h00, 8'h00, 1'b0, 1'b0);
    add_chk(ksc_pkg::ACT_BUILD, 8'h00, 8'h00, 1'b1, 1'b0);
    add_cfg(ksc_pkg::MODE_SHIFT_ENC, 5'd25);
    add_chk(ksc_pkg::ACT_CHAR, "Z", "Y", 1'b0, 1'b0);
    add_row(ksc_pkg::ACT_CHAR, "z");
    add_cfg(ksc_pkg::MODE_SHIFT_DEC, 5'd25);
    add_chk(ksc_pkg::ACT_CHAR, "A", "B", 1'b0, 1'b0);
    add_chk(ksc_pkg::ACT_CHAR, "a", "a", 1'b0, 1'b0);
    add_cfg(ksc_pkg::MODE_SUB_ENC, 5'd25);
    // keyword with a repeated letter
    add_row(ksc_pkg::ACT_APPEND, "k");
    add_row(ksc_pkg::ACT_APPEND, "E");
    add_row(ksc_pkg::ACT_APPEND, "y");
    add_row(ksc_pkg::ACT_APPEND, "k");
    add_chk(ksc_pkg::ACT_BUILD, 8'h00, 8'h00, 1'b1, 1'b0);
    add_row(ksc_pkg::ACT_CHAR, "a");
    add_row(ksc_pkg::ACT_CHAR, "z");
    add_chk(ksc_pkg::ACT_CHAR, "@", "@", 1'b0, 1'b0);
    add_cfg(ksc_pkg::MODE_SUB_DEC, 5'd0);
    add_row(ksc_pkg::ACT_CHAR, "K");
    add_chk(ksc_pkg::ACT_CHAR, "[", "[", 1'b0, 1'b0);
    add_chk(ksc_pkg::ACT_CHAR, "q", "q", 1'b0, 1'b0);
    // non-letter in the keyword fails the build and drops the table
    add_row(ksc_pkg::ACT_APPEND, "1");
    add_chk(ksc_pkg::ACT_BUILD, 8'h00, 8'h00, 1'b1, 1'b1);
    add_chk(ksc_pkg::ACT_CHAR, "K", "K", 1'b0, 1'b0);
    // empty keyword gives the plain alphabet
    add_row(ksc_pkg::ACT_CLEAR, 8'h00);
    add_chk(ksc_pkg::ACT_BUILD, 8'h00, 8'h00, 1'b1, 1'b0);
    add_row(ksc_pkg::ACT_CHAR, "A");

    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) begin
        drain();
        set_cipher(r.m, r.s);
      end else begin
        send_item(r.it);
        if (r.typed && cipher_out_q.size() != 0)
          cipher_out_q[cipher_out_q.size() - 1] = r.want;
      end
    end

    // random: three idling phases, each a run of setting segments
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 25 : (ph == 1) ? 62 : 0;
      while (n_items < (ph + 1) * TOTAL_ITEMS / 3) begin
        drain();
        m = ksc_pkg::mode_t'($urandom_range(3));
        case ($urandom_range(3))
          0:       s = 5'd0;
          1:       s = 5'd25;
          default: s = ksc_pkg::shift_t'($urandom_range(25));
        endcase
        set_cipher(m, s);
        repeat ($urandom_range(2, 5)) play_sequence();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("** keyword_substitution_cipher: PASSED **");
    end else begin
      $display("** keyword_substitution_cipher: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ksc_pkg.sv
hw/rtl/ksc_ram.sv
hw/rtl/keyword_substitution_cipher.sv
tb/keyword_substitution_cipher_tb.sv
